// ===== rtl/core/vra_pkg.sv =====
// Shared types, fixed widths and the square-root step for the vector align rotation block.
// No dependencies.
package vra_pkg;

	localparam int VW    = 17;   // aligned vector component, |v| <= 32768
	localparam int PW    = 33;   // products, cross and dot terms (signed)
	localparam int SQW   = 64;   // radicand width
	localparam int SQ_N  = 32;   // root bits, one per sqrt stage
	localparam int RW    = 33;   // rounded root, divider remainder
	localparam int OW    = 16;   // output entry width

	typedef logic [2:0][VW-1:0] vec3_t;
	typedef logic [2:0][PW-1:0] cvec_t;

	typedef struct packed {
		logic [SQW-1:0] rem;
		logic [SQW-1:0] root;
	} sq_state_t;

	function automatic sq_state_t sq_step(input sq_state_t x, input logic [SQW-1:0] b);
		logic [SQW:0] t;
		sq_state_t    y;
		t = {1'b0, x.root} + {1'b0, b};
		if ({1'b0, x.rem} >= t) begin
			y.rem  = x.rem - t[SQW-1:0];
			y.root = (x.root >> 1) + b;
		end else begin
			y.rem  = x.rem;
			y.root = x.root >> 1;
		end
		return y;
	endfunction

endpackage

// ===== rtl/core/vector_align_rotation_matrix_top.sv =====
// Rotation matrix (Rodrigues form) that turns vector a toward vector b.
// Depends on vra_pkg.
//
// Fully pipelined: one vector pair per cycle while the output is not stalled, through
// the 32-stage digit-by-digit square roots and the FRAC_BITS+1-stage restoring dividers.
// Output entries are signed with FRAC_BITS fraction bits, clamped to [-1.0, 1.0] and
// cut to 16 bits. When a x b is zero the identity is given with degenerate set. A stalled
// output lets bubbles in the pipe close up, so new pairs keep being taken until every
// stage holds an item.
module vector_align_rotation_matrix_top import vra_pkg::*; #(
	parameter int IN_WIDTH  = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [IN_WIDTH-1:0] a_x,
	input  logic signed [IN_WIDTH-1:0] a_y,
	input  logic signed [IN_WIDTH-1:0] a_z,
	input  logic signed [IN_WIDTH-1:0] b_x,
	input  logic signed [IN_WIDTH-1:0] b_y,
	input  logic signed [IN_WIDTH-1:0] b_z,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OW-1:0]       m00,
	output logic signed [OW-1:0]       m01,
	output logic signed [OW-1:0]       m02,
	output logic signed [OW-1:0]       m10,
	output logic signed [OW-1:0]       m11,
	output logic signed [OW-1:0]       m12,
	output logic signed [OW-1:0]       m20,
	output logic signed [OW-1:0]       m21,
	output logic signed [OW-1:0]       m22,
	output logic                       degenerate
);

	localparam int QW     = FRAC_BITS + 1;
	localparam int MW     = FRAC_BITS + 3;
	localparam int NW     = RW + FRAC_BITS;
	localparam int EW     = (MW + 1 > OW) ? MW + 1 : OW;
	localparam int SH_MAX = (IN_WIDTH > 16) ? IN_WIDTH - 16 : 0;
	localparam int ST_SQ  = 4;
	localparam int ST_RND = ST_SQ + SQ_N + 1;
	localparam int ST_DV  = ST_RND + 1;
	localparam int ST_P7  = ST_DV + QW + 1;
	localparam int ST_P8  = ST_P7 + 1;
	localparam int ST_P9  = ST_P8 + 1;
	localparam int ST_OUT = ST_P9 + 1;
	localparam int NST    = ST_OUT + 1;

	localparam logic [QW-1:0]        ONE_Q = QW'(1) << FRAC_BITS;
	localparam logic signed [MW-1:0] ONE_M = MW'(1) << FRAC_BITS;
	localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;

	function automatic vec3_t front(input logic [2:0][IN_WIDTH-1:0] v);
		logic [IN_WIDTH-1:0] mg [3];
		logic [IN_WIDTH-1:0] mx;
		logic [IN_WIDTH-1:0] t;
		logic [4:0]          sh;
		vec3_t               o;
		mx = '0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = v[i][IN_WIDTH-1] ? -v[i] : v[i];
			if (mg[i] > mx)
				mx = mg[i];
		end
		sh = '0;
		for (int s = SH_MAX; s >= 0; s--)
			if (33'(mx >> s) <= 33'd32768)
				sh = 5'(s);
		for (int i = 0; i < 3; i++) begin
			t    = mg[i] >> sh;
			o[i] = v[i][IN_WIDTH-1] ? -VW'(t) : VW'(t);
		end
		return o;
	endfunction

	function automatic logic signed [PW-1:0] smul(input logic [VW-1:0] x, input logic [VW-1:0] y);
		logic signed [PW-1:0] xe;
		logic signed [PW-1:0] ye;
		xe = PW'($signed(x));
		ye = PW'($signed(y));
		return xe * ye;
	endfunction

	function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] x,
			input logic signed [MW-1:0] y);
		logic [MW-2:0]   ax;
		logic [MW-2:0]   ay;
		logic [2*MW-3:0] p;
		logic [2*MW-3:0] r;
		ax = (MW-1)'(x[MW-1] ? -x : x);
		ay = (MW-1)'(y[MW-1] ? -y : y);
		p  = ax * ay;
		r  = (p + ((2*MW-2)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return (x[MW-1] ^ y[MW-1]) ? -$signed(MW'(r)) : $signed(MW'(r));
	endfunction

	function automatic logic [OW-1:0] clampo(input logic signed [EW-1:0] x);
		logic signed [EW-1:0] c;
		c = (x > ONE_E) ? ONE_E : ((x < -ONE_E) ? -ONE_E : x);
		return c[OW-1:0];
	endfunction

	// handshake: a stage moves when empty or when the one after it moves
	logic [NST-1:0] v_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !v_q[NST-1] || !out_stall;
		for (int i = NST - 2; i >= 0; i--)
			adv[i] = !v_q[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int i = 1; i < NST; i++)
				if (adv[i])
					v_q[i] <= v_q[i-1];
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = v_q[NST-1];

	// front end, products, sums
	vec3_t                a_s1, b_s1;
	logic signed [PW-1:0] prod_s2 [15];
	cvec_t                c_s3, c_s4;
	logic signed [PW-1:0] d_s3, d_s4;
	logic [31:0]          na2_s3, nb2_s3;
	logic [SQW-1:0]       p2_s4;
	logic [SQW-1:0]       csq_s4 [3];
	logic                 deg_s4;
	logic [31:0]          cm [3];

	always_comb
		for (int i = 0; i < 3; i++)
			cm[i] = 32'(c_s3[i][PW-1] ? -$signed(c_s3[i]) : $signed(c_s3[i]));

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			a_s1 <= front({a_z, a_y, a_x});
			b_s1 <= front({b_z, b_y, b_x});
		end
		if (adv[1]) begin
			prod_s2[0] <= smul(a_s1[1], b_s1[2]);
			prod_s2[1] <= smul(a_s1[2], b_s1[1]);
			prod_s2[2] <= smul(a_s1[2], b_s1[0]);
			prod_s2[3] <= smul(a_s1[0], b_s1[2]);
			prod_s2[4] <= smul(a_s1[0], b_s1[1]);
			prod_s2[5] <= smul(a_s1[1], b_s1[0]);
			for (int i = 0; i < 3; i++) begin
				prod_s2[6+i]  <= smul(a_s1[i], b_s1[i]);
				prod_s2[9+i]  <= smul(a_s1[i], a_s1[i]);
				prod_s2[12+i] <= smul(b_s1[i], b_s1[i]);
			end
		end
		if (adv[2]) begin
			c_s3[0] <= prod_s2[0] - prod_s2[1];
			c_s3[1] <= prod_s2[2] - prod_s2[3];
			c_s3[2] <= prod_s2[4] - prod_s2[5];
			d_s3    <= prod_s2[6] + prod_s2[7] + prod_s2[8];
			na2_s3  <= 32'(prod_s2[9] + prod_s2[10] + prod_s2[11]);
			nb2_s3  <= 32'(prod_s2[12] + prod_s2[13] + prod_s2[14]);
		end
		if (adv[3]) begin
			c_s4   <= c_s3;
			d_s4   <= d_s3;
			deg_s4 <= (c_s3 == '0);
			p2_s4  <= SQW'(na2_s3) * SQW'(nb2_s3);
			for (int i = 0; i < 3; i++)
				csq_s4[i] <= SQW'(cm[i]) * SQW'(cm[i]);
		end
	end

	// square roots of |a|^2|b|^2 and |a x b|^2, one root bit per stage
	sq_state_t            sqp_s   [SQ_N+1];
	sq_state_t            sqq_s   [SQ_N+1];
	cvec_t                sq_c_s  [SQ_N+1];
	logic signed [PW-1:0] sq_d_s  [SQ_N+1];
	logic                 sq_deg_s[SQ_N+1];

	always_ff @(posedge clk) begin
		if (adv[ST_SQ]) begin
			sqp_s[0]    <= '{rem: p2_s4, root: '0};
			sqq_s[0]    <= '{rem: csq_s4[0] + csq_s4[1] + csq_s4[2], root: '0};
			sq_c_s[0]   <= c_s4;
			sq_d_s[0]   <= d_s4;
			sq_deg_s[0] <= deg_s4;
		end
	end

	for (genvar k = 1; k <= SQ_N; k++) begin : g_sq
		localparam logic [SQW-1:0] BITV = SQW'(1) << (SQW - 2*k);
		always_ff @(posedge clk) begin
			if (adv[ST_SQ+k]) begin
				sqp_s[k]    <= sq_step(sqp_s[k-1], BITV);
				sqq_s[k]    <= sq_step(sqq_s[k-1], BITV);
				sq_c_s[k]   <= sq_c_s[k-1];
				sq_d_s[k]   <= sq_d_s[k-1];
				sq_deg_s[k] <= sq_deg_s[k-1];
			end
		end
	end

	logic [RW-1:0]        s_s6, cr_s6;
	cvec_t                c_s6;
	logic signed [PW-1:0] d_s6;
	logic                 deg_s6;

	always_ff @(posedge clk) begin
		if (adv[ST_RND]) begin
			s_s6   <= {1'b0, sqp_s[SQ_N].root[RW-2:0]} +
				RW'(sqp_s[SQ_N].rem > sqp_s[SQ_N].root);
			cr_s6  <= {1'b0, sqq_s[SQ_N].root[RW-2:0]} +
				RW'(sqq_s[SQ_N].rem > sqq_s[SQ_N].root);
			c_s6   <= sq_c_s[SQ_N];
			d_s6   <= sq_d_s[SQ_N];
			deg_s6 <= sq_deg_s[SQ_N];
		end
	end

	// rounded divisions: lane 0 cos, lane 1 sin, lanes 2..4 axis
	logic [RW-1:0] dv_rem_s [QW+1][5];
	logic [QW-1:0] dv_nlo_s [QW+1][5];
	logic [QW-1:0] dv_q_s   [QW+1][5];
	logic [RW-1:0] dv_sd_s  [QW+1];
	logic [RW-1:0] dv_cd_s  [QW+1];
	logic [3:0]    dv_neg_s [QW+1];
	logic          dv_deg_s [QW+1];
	logic [RW-1:0] mag0 [5];
	logic [RW-1:0] den0 [5];
	logic [NW-1:0] num0 [5];

	always_comb begin
		mag0[0] = RW'(d_s6[PW-1] ? -d_s6 : d_s6);
		mag0[1] = cr_s6;
		den0[0] = s_s6;
		den0[1] = s_s6;
		for (int i = 0; i < 3; i++) begin
			mag0[2+i] = RW'(c_s6[i][PW-1] ? -$signed(c_s6[i]) : $signed(c_s6[i]));
			den0[2+i] = cr_s6;
		end
		for (int l = 0; l < 5; l++)
			num0[l] = (NW'(mag0[l]) << FRAC_BITS) + NW'(den0[l] >> 1);
	end

	always_ff @(posedge clk) begin
		if (adv[ST_DV]) begin
			for (int l = 0; l < 5; l++) begin
				dv_rem_s[0][l] <= RW'(num0[l] >> QW);
				dv_nlo_s[0][l] <= num0[l][QW-1:0];
				dv_q_s[0][l]   <= '0;
			end
			dv_sd_s[0]  <= s_s6;
			dv_cd_s[0]  <= cr_s6;
			dv_neg_s[0] <= {c_s6[2][PW-1], c_s6[1][PW-1], c_s6[0][PW-1], d_s6[PW-1]};
			dv_deg_s[0] <= deg_s6;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_dv
		logic [RW:0]   t   [5];
		logic [RW-1:0] den [5];
		logic          ge  [5];

		always_comb
			for (int l = 0; l < 5; l++) begin
				den[l] = (l < 2) ? dv_sd_s[j-1] : dv_cd_s[j-1];
				t[l]   = {dv_rem_s[j-1][l], dv_nlo_s[j-1][l][QW-1]};
				ge[l]  = t[l] >= {1'b0, den[l]};
			end

		always_ff @(posedge clk) begin
			if (adv[ST_DV+j]) begin
				for (int l = 0; l < 5; l++) begin
					dv_rem_s[j][l] <= ge[l] ? RW'(t[l] - {1'b0, den[l]}) : RW'(t[l]);
					dv_nlo_s[j][l] <= dv_nlo_s[j-1][l] << 1;
					dv_q_s[j][l]   <= {dv_q_s[j-1][l][QW-2:0], ge[l]};
				end
				dv_sd_s[j]  <= dv_sd_s[j-1];
				dv_cd_s[j]  <= dv_cd_s[j-1];
				dv_neg_s[j] <= dv_neg_s[j-1];
				dv_deg_s[j] <= dv_deg_s[j-1];
			end
		end
	end

	// matrix assembly
	logic [QW-1:0]        qc [5];
	logic signed [MW-1:0] cos_s7, sin_s7, omc_s7, cos_s8, cos_s9;
	logic signed [MW-1:0] k_s7 [3];
	logic signed [MW-1:0] k_s8 [3];
	logic signed [MW-1:0] sv_s8 [3];
	logic signed [MW-1:0] u_s8 [3];
	logic signed [MW-1:0] sv_s9 [3];
	logic signed [MW-1:0] mm_s9 [9];
	logic                 deg_s7, deg_s8, deg_s9;
	logic signed [EW-1:0] sum [9];
	logic [OW-1:0]        m_s10 [9];
	logic                 deg_s10;
	logic signed [MW-1:0] cosn;

	always_comb begin
		for (int l = 0; l < 5; l++)
			qc[l] = (dv_q_s[QW][l] > ONE_Q) ? ONE_Q : dv_q_s[QW][l];
		cosn = dv_neg_s[QW][0] ? -$signed(MW'(qc[0])) : $signed(MW'(qc[0]));
	end

	always_ff @(posedge clk) begin
		if (adv[ST_P7]) begin
			cos_s7 <= cosn;
			omc_s7 <= ONE_M - cosn;
			sin_s7 <= MW'(qc[1]);
			for (int i = 0; i < 3; i++)
				k_s7[i] <= dv_neg_s[QW][1+i] ? -$signed(MW'(qc[2+i])) : $signed(MW'(qc[2+i]));
			deg_s7 <= dv_deg_s[QW];
		end
		if (adv[ST_P8]) begin
			for (int i = 0; i < 3; i++) begin
				sv_s8[i] <= mulq(sin_s7, k_s7[i]);
				u_s8[i]  <= mulq(omc_s7, k_s7[i]);
				k_s8[i]  <= k_s7[i];
			end
			cos_s8 <= cos_s7;
			deg_s8 <= deg_s7;
		end
		if (adv[ST_P9]) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mm_s9[3*i+j] <= mulq(u_s8[i], k_s8[j]);
			sv_s9  <= sv_s8;
			cos_s9 <= cos_s8;
			deg_s9 <= deg_s8;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++)
			sum[i] = EW'(mm_s9[i]);
		sum[0] = sum[0] + EW'(cos_s9);
		sum[4] = sum[4] + EW'(cos_s9);
		sum[8] = sum[8] + EW'(cos_s9);
		sum[1] = sum[1] - EW'(sv_s9[2]);
		sum[2] = sum[2] + EW'(sv_s9[1]);
		sum[3] = sum[3] + EW'(sv_s9[2]);
		sum[5] = sum[5] - EW'(sv_s9[0]);
		sum[6] = sum[6] - EW'(sv_s9[1]);
		sum[7] = sum[7] + EW'(sv_s9[0]);
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			for (int i = 0; i < 9; i++)
				if (deg_s9)
					m_s10[i] <= (i % 4 == 0) ? ONE_E[OW-1:0] : '0;
				else
					m_s10[i] <= clampo(sum[i]);
			deg_s10 <= deg_s9;
		end
	end

	assign m00        = m_s10[0];
	assign m01        = m_s10[1];
	assign m02        = m_s10[2];
	assign m10        = m_s10[3];
	assign m11        = m_s10[4];
	assign m12        = m_s10[5];
	assign m20        = m_s10[6];
	assign m21        = m_s10[7];
	assign m22        = m_s10[8];
	assign degenerate = deg_s10;

endmodule

// ===== tb/sv/vector_align_rotation_matrix_top_tb.sv =====
// Self-checking testbench for vector_align_rotation_matrix_top: random and directed vector
// pairs are predicted in integer arithmetic and compared against every output transfer.
// Depends on vra_pkg and the RTL of the block.
module vector_align_rotation_matrix_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vra_pkg::*;

	localparam int FRAC = 14;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam int LATENCY = FRAC + 44;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [15:0] v[6];
	} pair_t;

	typedef struct {
		logic [15:0] m[9];
		logic        dgn;
	} matrix_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic degenerate;

	pair_t   pending_pairs[$];
	matrix_t expected_matrices[$];
	int      error_count = 0;
	int      idle_cycles = 0;
	int      send_idle_pct = 7;
	int      recv_idle_pct = 88;
	bit      hold_sender = 0;
	bit      pairs_done = 0;
	bit      in_taken = 0;

	vector_align_rotation_matrix_top DUT (.*);

	always #10 clk = ~clk;

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint isqrt_round(longint unsigned v);
		longint unsigned r, lo, hi, mid;
		lo = 0;
		hi = 64'd4294967296;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		r = lo;
		if (v - r * r > r) r++;
		return r;
	endfunction

	function automatic longint div_rnd(longint num, longint den);
		longint q;
		q = (mag(num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint mul_fix(longint x, longint y);
		longint q;
		q = (mag(x) * mag(y) + (64'sd1 << (FRAC - 1))) >>> FRAC;
		return ((x < 0) != (y < 0)) ? -q : q;
	endfunction

	function automatic longint sat_one(longint v);
		return v > ONE ? ONE : (v < -ONE ? -ONE : v);
	endfunction

	function automatic matrix_t rotation_of(pair_t p);
		matrix_t r;
		longint a[3], b[3], c[3], k[3], sk[3], uk[3], mm[9];
		longint d, cosq, sinq, omc;
		longint unsigned na2, nb2, q2, s_len, c_len;
		for (int i = 0; i < 3; i++) begin
			a[i] = p.v[i];
			b[i] = p.v[3 + i];
		end
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
			for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? ONE[15:0] : 16'h0;
			r.dgn = 1;
			return r;
		end
		d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		na2 = 0; nb2 = 0; q2 = 0;
		for (int i = 0; i < 3; i++) begin
			na2 += a[i] * a[i];
			nb2 += b[i] * b[i];
			q2 += longint'(mag(c[i])) * longint'(mag(c[i]));
		end
		s_len = isqrt_round(na2 * nb2);
		c_len = isqrt_round(q2);
		cosq = sat_one(div_rnd(d * ONE, s_len));
		sinq = sat_one(div_rnd(longint'(c_len) * ONE, s_len));
		omc = ONE - cosq;
		for (int i = 0; i < 3; i++) begin
			k[i] = div_rnd(c[i] * ONE, c_len);
			sk[i] = mul_fix(sinq, k[i]);
			uk[i] = mul_fix(omc, k[i]);
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) mm[i * 3 + j] = mul_fix(uk[i], k[j]);
		mm[0] += cosq; mm[4] += cosq; mm[8] += cosq;
		mm[1] -= sk[2]; mm[2] += sk[1]; mm[3] += sk[2];
		mm[5] -= sk[0]; mm[6] -= sk[1]; mm[7] += sk[0];
		for (int i = 0; i < 9; i++) r.m[i] = 16'(sat_one(mm[i]));
		r.dgn = 0;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz);
		pair_t p;
		p.v[0] = 16'(ax); p.v[1] = 16'(ay); p.v[2] = 16'(az);
		p.v[3] = 16'(bx); p.v[4] = 16'(by); p.v[5] = 16'(bz);
		return p;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (!hold_sender && pending_pairs.size() > 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					pair_t p;
					p = pending_pairs.pop_front();
					a_x <= p.v[0]; a_y <= p.v[1]; a_z <= p.v[2];
					b_x <= p.v[3]; b_y <= p.v[4]; b_z <= p.v[5];
					expected_matrices.push_back(rotation_of(p));
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_matrices.size() == 0) begin
					report_mismatch("unexpected transfer", 0, 0);
				end else begin
					matrix_t e;
					logic [15:0] got[9];
					e = expected_matrices.pop_front();
					got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
					for (int i = 0; i < 9; i++)
						if (got[i] !== e.m[i])
							report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
								$signed(got[i]), $signed(e.m[i]));
					if (degenerate !== e.dgn) report_mismatch("degenerate", degenerate, e.dgn);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0));
		pending_pairs.push_back(make_pair(0, 1, 0, 1, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 5, 6, 7));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(3, 4, 5, 6, 8, 10));
		pending_pairs.push_back(make_pair(3, 4, 5, -3, -4, -5));
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, -32768));
		pending_pairs.push_back(make_pair(32767, 0, 0, 0, 0, 32767));
		pending_pairs.push_back(make_pair(-32768, 0, 0, 0, -32768, 0));
		pending_pairs.push_back(make_pair(32767, 32767, 32767, -32768, 32767, -32768));
		pending_pairs.push_back(make_pair(1, 0, 0, 32767, 1, 0));
		pending_pairs.push_back(make_pair(32767, 1, 0, 32767, 0, 1));
		pending_pairs.push_back(make_pair(1, 1, 1, 1, 1, 2));
		pending_pairs.push_back(make_pair(-1, 2, -3, 4, -5, 6));
		pending_pairs.push_back(make_pair(-32768, 32767, 1, 1, -32768, 32767));
		for (int n = 0; n < 1350; n++) begin
			pair_t p;
			for (int i = 0; i < 6; i++) p.v[i] = rand_comp();
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < 3; i++) p.v[3 + i] = -p.v[i];
			pending_pairs.push_back(p);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (pending_pairs.size() < 900);
		hold_sender = 1;
		wait (expected_matrices.size() == 0);
		@(negedge clk);
		hold_sender = 0;
		send_idle_pct = 88;
		recv_idle_pct = 7;
		wait (pending_pairs.size() < 450);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait (pending_pairs.size() == 0);
		wait (expected_matrices.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
